### rtl/llfp_pkg.sv
// ----------------------------------------------------------------------------
// Log line field parser: shared definitions
// Payload structs, layout table, character constants and small decode helpers.
// ----------------------------------------------------------------------------
package llfp_pkg;

    localparam int CHAR_W         = 8;
    localparam int POS_W          = 12;
    localparam int MAX_LINE_BYTES = 4096;
    localparam int POS_CAP_INT    = ((MAX_LINE_BYTES - 1) < ((1 << POS_W) - 1)) ?
                                    (MAX_LINE_BYTES - 1) : ((1 << POS_W) - 1);
    localparam logic [POS_W-1:0] POS_CAP = POS_CAP_INT[POS_W-1:0];

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MIN_LINE_LENGTH = 1'b0;   // register index, from paddr[2]
    localparam logic [CHAR_W-1:0] MIN_LEN_RESET = 8'd30;

    // Characters of the layout
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_V      = 8'h56;
    localparam logic [CHAR_W-1:0] CH_D      = 8'h44;
    localparam logic [CHAR_W-1:0] CH_I      = 8'h49;
    localparam logic [CHAR_W-1:0] CH_W      = 8'h57;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h45;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h46;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h53;
    // Marker in the layout table for a slot that takes a decimal digit.
    localparam logic [CHAR_W-1:0] DIGIT_SLOT = 8'h00;

    // Fixed-width date and time prefix "MM-DD HH:MM:SS.mmm".
    localparam int FIXED_LEN   = 18;
    localparam int FIXED_IDX_W = $clog2(FIXED_LEN);
    localparam int DATE_SLOTS  = 5;
    localparam logic [FIXED_IDX_W-1:0] FIXED_LAST = FIXED_IDX_W'(FIXED_LEN - 1);
    localparam logic [FIXED_IDX_W-1:0] DATE_END   = FIXED_IDX_W'(DATE_SLOTS);
    localparam logic [CHAR_W-1:0] FIXED_LAYOUT [0:FIXED_LEN-1] = '{
        DIGIT_SLOT, DIGIT_SLOT, CH_DASH, DIGIT_SLOT, DIGIT_SLOT, CH_SPACE,
        DIGIT_SLOT, DIGIT_SLOT, CH_COLON, DIGIT_SLOT, DIGIT_SLOT, CH_COLON,
        DIGIT_SLOT, DIGIT_SLOT, CH_DOT, DIGIT_SLOT, DIGIT_SLOT, DIGIT_SLOT
    };

    // Level and severity codes
    localparam logic [2:0] LVL_V = 3'd0;
    localparam logic [2:0] LVL_D = 3'd1;
    localparam logic [2:0] LVL_I = 3'd2;
    localparam logic [2:0] LVL_W = 3'd3;
    localparam logic [2:0] LVL_E = 3'd4;
    localparam logic [2:0] LVL_F = 3'd5;
    localparam logic [2:0] LVL_S = 3'd6;
    localparam logic [1:0] SEV_INFO    = 2'd0;
    localparam logic [1:0] SEV_WARNING = 2'd1;
    localparam logic [1:0] SEV_ERROR   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              last_in_line;
    } in_item_t;

    typedef struct packed {
        logic              line_ok;
        logic [15:0]       date_bcd;
        logic [35:0]       time_bcd;
        logic [31:0]       process_number;
        logic [31:0]       thread_number;
        logic [2:0]        level_code;
        logic [1:0]        severity_code;
        logic [POS_W-1:0]  tag_offset;
        logic [POS_W-1:0]  tag_length;
        logic [POS_W-1:0]  message_offset;
        logic [POS_W-1:0]  line_length;
    } out_item_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } level_decode_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v < POS_CAP) ? v + 1'b1 : POS_CAP;
    endfunction

    function automatic level_decode_t level_of(input logic [CHAR_W-1:0] c);
        level_decode_t r;
        r.hit = 1'b1;
        case (c)
            CH_V:    r.code = LVL_V;
            CH_D:    r.code = LVL_D;
            CH_I:    r.code = LVL_I;
            CH_W:    r.code = LVL_W;
            CH_E:    r.code = LVL_E;
            CH_F:    r.code = LVL_F;
            CH_S:    r.code = LVL_S;
            default: begin
                r.hit  = 1'b0;
                r.code = LVL_V;
            end
        endcase
        return r;
    endfunction

    function automatic logic [1:0] severity_of(input logic [2:0] lvl);
        logic [1:0] s;
        case (lvl)
            LVL_W:        s = SEV_WARNING;
            LVL_E, LVL_F: s = SEV_ERROR;
            default:      s = SEV_INFO;
        endcase
        return s;
    endfunction

endpackage

### rtl/log_line_field_parser_unit.sv
// ----------------------------------------------------------------------------
// Log line field parser unit
// Parses one byte of a log line per transfer and emits one record per line.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid / s_ready  llfp_pkg::in_item_t  (one byte)
//  m_        out        m_valid / m_ready  llfp_pkg::out_item_t (one record)
//  APB       in/out     psel/penable/...   min_line_length at byte address 0
//
//  One byte is taken in every cycle unless a line's last byte waits on a
//  held result; a record leaves through the input register and then the
//  result register. The rate is set by the byte state machine, which closes
//  its loop over the line state with one shared times-ten accumulator.
//  Reset (aresetn low, synchronous) empties both registers, sets the line
//  state to the first month digit and min_line_length to 30.
//  Only the last byte of a line waits on a held result; other bytes flow on.
//
// The block checks "MM-DD HH:MM:SS.mmm [spaces] PID spaces TID space LEVEL
// space Tag: message". The first byte that breaks the layout marks the line as
// failed; the rest of the line is then only counted. A failed record carries
// zero in every field except the line length.

module log_line_field_parser_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  llfp_pkg::in_item_t                s_data,
    // record output
    output logic                              m_valid,
    input  logic                              m_ready,
    output llfp_pkg::out_item_t               m_data,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [llfp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [llfp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [llfp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    // Parser phases. The fixed date and time prefix is a single phase that
    // walks the layout table through fixed_idx_reg.
    typedef enum logic [10:0] {
        PH_FIXED       = 11'b000_0000_0001,
        PH_PID_SKIP    = 11'b000_0000_0010,
        PH_PID         = 11'b000_0000_0100,
        PH_TID_SKIP    = 11'b000_0000_1000,
        PH_TID         = 11'b000_0001_0000,
        PH_LEVEL       = 11'b000_0010_0000,
        PH_LEVEL_SP    = 11'b000_0100_0000,
        PH_TAG_FIRST   = 11'b000_1000_0000,
        PH_TAG         = 11'b001_0000_0000,
        PH_AFTER_COLON = 11'b010_0000_0000,
        PH_MESSAGE     = 11'b100_0000_0000
    } phase_t;

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    logic [llfp_pkg::CHAR_W-1:0] min_len_reg;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == llfp_pkg::REG_MIN_LINE_LENGTH);
    assign prdata    = (paddr[2] == llfp_pkg::REG_MIN_LINE_LENGTH) ?
                       {{(llfp_pkg::APB_DATA_W - llfp_pkg::CHAR_W){1'b0}}, min_len_reg} :
                       '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg <= llfp_pkg::MIN_LEN_RESET;
        end else if (cfg_write) begin
            min_len_reg <= pwdata[llfp_pkg::CHAR_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    logic                        in_valid_reg;
    logic [llfp_pkg::CHAR_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        proc_fire;
    logic                        out_load;
    logic                        m_valid_reg;

    // A byte is processed whenever one is held, unless it closes a line and
    // the previous record has not yet been taken.
    assign proc_fire = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign out_load  = proc_fire && in_last_reg;
    assign s_ready   = !in_valid_reg || proc_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data.char_byte;
            in_last_reg <= s_data.last_in_line;
        end
    end

    // ---------------------------------------------------------------------
    // Line state
    // ---------------------------------------------------------------------
    phase_t                           phase_reg,      phase_next;
    logic [llfp_pkg::FIXED_IDX_W-1:0] fixed_idx_reg,  fixed_idx_next;
    logic [llfp_pkg::POS_W-1:0]       byte_pos_reg,   byte_pos_next;
    logic                             failed_reg,     failed_next;
    logic [15:0]                      date_reg,       date_next;
    logic [35:0]                      time_reg,       time_next;
    logic [31:0]                      pid_reg,        pid_next;
    logic [31:0]                      tid_reg,        tid_next;
    logic [2:0]                       level_reg,      level_next;
    logic [llfp_pkg::POS_W-1:0]       tag_start_reg,  tag_start_next;
    logic [llfp_pkg::POS_W-1:0]       tag_len_reg,    tag_len_next;
    logic [llfp_pkg::POS_W-1:0]       msg_start_reg,  msg_start_next;

    logic                             is_digit;
    logic [3:0]                       digit;
    logic [llfp_pkg::POS_W-1:0]       pos_inc;
    logic [llfp_pkg::CHAR_W-1:0]      want;
    logic [31:0]                      acc_src;
    logic [35:0]                      acc_prod;
    logic [31:0]                      acc_sat;
    llfp_pkg::level_decode_t          lvl;

    assign is_digit = (in_byte_reg >= llfp_pkg::CH_ZERO) && (in_byte_reg <= llfp_pkg::CH_NINE);
    assign digit    = in_byte_reg[3:0];
    assign pos_inc  = llfp_pkg::sat_inc(byte_pos_reg);
    assign want     = llfp_pkg::FIXED_LAYOUT[fixed_idx_reg];
    assign lvl      = llfp_pkg::level_of(in_byte_reg);

    // Shared decimal accumulator: acc * 10 + digit, saturating at 2^32-1.
    // Only one of the two id fields is ever being collected.
    assign acc_src  = ((phase_reg == PH_TID_SKIP) || (phase_reg == PH_TID)) ? tid_reg : pid_reg;
    assign acc_prod = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0} + {32'd0, digit};
    assign acc_sat  = (|acc_prod[35:32]) ? 32'hFFFF_FFFF : acc_prod[31:0];

    always_comb begin
        phase_next     = phase_reg;
        fixed_idx_next = fixed_idx_reg;
        byte_pos_next  = pos_inc;
        failed_next    = failed_reg;
        date_next      = date_reg;
        time_next      = time_reg;
        pid_next       = pid_reg;
        tid_next       = tid_reg;
        level_next     = level_reg;
        tag_start_next = tag_start_reg;
        tag_len_next   = tag_len_reg;
        msg_start_next = msg_start_reg;

        if (!failed_reg) begin
            case (phase_reg)
                PH_FIXED: begin
                    if ((want == llfp_pkg::DIGIT_SLOT) ? !is_digit : (in_byte_reg != want)) begin
                        failed_next = 1'b1;
                    end else begin
                        if (want == llfp_pkg::DIGIT_SLOT) begin
                            if (fixed_idx_reg < llfp_pkg::DATE_END) begin
                                date_next = {date_reg[11:0], digit};
                            end else begin
                                time_next = {time_reg[31:0], digit};
                            end
                        end
                        if (fixed_idx_reg == llfp_pkg::FIXED_LAST) begin
                            fixed_idx_next = '0;
                            phase_next     = PH_PID_SKIP;
                        end else begin
                            fixed_idx_next = fixed_idx_reg + 1'b1;
                        end
                    end
                end
                PH_PID_SKIP: begin
                    if (in_byte_reg != llfp_pkg::CH_SPACE) begin
                        if (!is_digit) begin
                            failed_next = 1'b1;
                        end else begin
                            pid_next   = acc_sat;
                            phase_next = PH_PID;
                        end
                    end
                end
                PH_PID: begin
                    if (is_digit) begin
                        pid_next = acc_sat;
                    end else if (in_byte_reg == llfp_pkg::CH_SPACE) begin
                        phase_next = PH_TID_SKIP;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_TID_SKIP: begin
                    if (in_byte_reg != llfp_pkg::CH_SPACE) begin
                        if (!is_digit) begin
                            failed_next = 1'b1;
                        end else begin
                            tid_next   = acc_sat;
                            phase_next = PH_TID;
                        end
                    end
                end
                PH_TID: begin
                    if (is_digit) begin
                        tid_next = acc_sat;
                    end else if (in_byte_reg == llfp_pkg::CH_SPACE) begin
                        phase_next = PH_LEVEL;
                    end else begin
                        failed_next = 1'b1;
                    end
                end
                PH_LEVEL: begin
                    if (!lvl.hit) begin
                        failed_next = 1'b1;
                    end else begin
                        level_next = lvl.code;
                        phase_next = PH_LEVEL_SP;
                    end
                end
                PH_LEVEL_SP: begin
                    if (in_byte_reg != llfp_pkg::CH_SPACE) begin
                        failed_next = 1'b1;
                    end else begin
                        phase_next = PH_TAG_FIRST;
                    end
                end
                PH_TAG_FIRST: begin
                    if (in_byte_reg == llfp_pkg::CH_COLON) begin
                        failed_next = 1'b1;
                    end else begin
                        tag_start_next = byte_pos_reg;
                        tag_len_next   = llfp_pkg::POS_W'(1);
                        phase_next     = PH_TAG;
                    end
                end
                PH_TAG: begin
                    if (in_byte_reg == llfp_pkg::CH_COLON) begin
                        msg_start_next = pos_inc;
                        phase_next     = PH_AFTER_COLON;
                    end else begin
                        tag_len_next = llfp_pkg::sat_inc(tag_len_reg);
                    end
                end
                PH_AFTER_COLON: begin
                    // One space after the colon belongs to the separator.
                    msg_start_next = (in_byte_reg == llfp_pkg::CH_SPACE) ? pos_inc : byte_pos_reg;
                    phase_next     = PH_MESSAGE;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIXED;
            fixed_idx_reg <= '0;
            byte_pos_reg  <= '0;
            failed_reg    <= 1'b0;
            date_reg      <= '0;
            time_reg      <= '0;
            pid_reg       <= '0;
            tid_reg       <= '0;
            level_reg     <= '0;
            tag_start_reg <= '0;
            tag_len_reg   <= '0;
            msg_start_reg <= '0;
        end else if (proc_fire) begin
            if (in_last_reg) begin
                // The line is closed: start the next one from scratch.
                phase_reg     <= PH_FIXED;
                fixed_idx_reg <= '0;
                byte_pos_reg  <= '0;
                failed_reg    <= 1'b0;
                date_reg      <= '0;
                time_reg      <= '0;
                pid_reg       <= '0;
                tid_reg       <= '0;
                level_reg     <= '0;
                tag_start_reg <= '0;
                tag_len_reg   <= '0;
                msg_start_reg <= '0;
            end else begin
                phase_reg     <= phase_next;
                fixed_idx_reg <= fixed_idx_next;
                byte_pos_reg  <= byte_pos_next;
                failed_reg    <= failed_next;
                date_reg      <= date_next;
                time_reg      <= time_next;
                pid_reg       <= pid_next;
                tid_reg       <= tid_next;
                level_reg     <= level_next;
                tag_start_reg <= tag_start_next;
                tag_len_reg   <= tag_len_next;
                msg_start_reg <= msg_start_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    // The record is built from the state as it stands after the last byte.
    logic                line_ok;
    llfp_pkg::out_item_t rec_next;
    llfp_pkg::out_item_t rec_reg;

    assign line_ok = !failed_next &&
                     ((phase_next == PH_AFTER_COLON) || (phase_next == PH_MESSAGE)) &&
                     (byte_pos_next >= {{(llfp_pkg::POS_W - llfp_pkg::CHAR_W){1'b0}}, min_len_reg});

    always_comb begin
        rec_next = '0;
        rec_next.line_length = byte_pos_next;
        if (line_ok) begin
            rec_next.line_ok        = 1'b1;
            rec_next.date_bcd       = date_next;
            rec_next.time_bcd       = time_next;
            rec_next.process_number = pid_next;
            rec_next.thread_number  = tid_next;
            rec_next.level_code     = level_next;
            rec_next.severity_code  = llfp_pkg::severity_of(level_next);
            rec_next.tag_offset     = tag_start_next;
            rec_next.tag_length     = tag_len_next;
            rec_next.message_offset = msg_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            rec_reg <= rec_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rec_reg;

`ifndef ASSERT_OFF
    // Closing a line always returns the parser to the start of a fresh line.
    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (phase_reg == PH_FIXED) && (byte_pos_reg == '0) && !failed_reg)
        else $error("line state not cleared after the last byte");

    // A failed record carries nothing but its length.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.line_ok) |->
            (m_data.date_bcd == '0) && (m_data.time_bcd == '0) &&
            (m_data.process_number == '0) && (m_data.thread_number == '0) &&
            (m_data.tag_length == '0) && (m_data.message_offset == '0))
        else $error("failed record carries parsed fields");

    // A passing record has a non-empty tag that starts before the message.
    a_tag_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.line_ok) |->
            (m_data.tag_length != '0) && (m_data.message_offset >= m_data.tag_offset))
        else $error("passing record has an inconsistent tag");

    // A held record is not overwritten by the next line.
    a_hold_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(rec_reg)))
        else $error("pending record lost or changed");
`endif

endmodule

### bench/log_line_field_parser_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Log line field parser unit: testbench
// Sends log lines byte by byte into the unit and predicts each line record
// with its own behavioural parser. Every field of every record is compared.
// A table of directed lines runs first. Random lines follow under several
// settings of min_line_length, with random idling on both channels in all but the last.
// ----------------------------------------------------------------------------
module log_line_field_parser_unit_tb;

    // The receiver holds off for this long once, so that the unit fills up.
    localparam int LONG_HOLD_CYCLES = 120;
    // A record leaves through the input and result registers after its last byte.
    localparam int SETTLE_CYCLES    = 4;
    localparam int DRAIN_CYCLES     = 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam logic [llfp_pkg::CHAR_W-1:0] FILL_CHAR = 8'h61;
    localparam logic [llfp_pkg::CHAR_W-1:0] LEVEL_LETTERS [7] = '{
        llfp_pkg::CH_V, llfp_pkg::CH_D, llfp_pkg::CH_I, llfp_pkg::CH_W,
        llfp_pkg::CH_E, llfp_pkg::CH_F, llfp_pkg::CH_S};

    // Where the parser stands within a line. The date and time prefix is
    // walked slot by slot while in PH_FIXED.
    typedef enum logic [10:0] {
        PH_FIXED       = 11'b000_0000_0001,
        PH_PID_SKIP    = 11'b000_0000_0010,
        PH_PID         = 11'b000_0000_0100,
        PH_TID_SKIP    = 11'b000_0000_1000,
        PH_TID         = 11'b000_0001_0000,
        PH_LEVEL       = 11'b000_0010_0000,
        PH_LEVEL_SP    = 11'b000_0100_0000,
        PH_TAG_FIRST   = 11'b000_1000_0000,
        PH_TAG         = 11'b001_0000_0000,
        PH_AFTER_COLON = 11'b010_0000_0000,
        PH_MESSAGE     = 11'b100_0000_0000
    } parse_phase_t;

    // One row of the directed table. The line is the head, then 'fill' filler
    // bytes, then the tail. A rejected row has its record typed in directly:
    // every field is zero except the line length.
    typedef struct {
        int    min_len;   // register value written before the line, -1 keeps it
        string head;
        int    fill;
        string tail;
        bit    rejected;
    } line_case_t;

    localparam int NUM_CASES = 22;
    line_case_t line_cases [NUM_CASES] = '{
        // Well-formed lines under the reset minimum of 30 bytes. Every level
        // letter appears, together with both saturating counters and a glued PID.
        '{-1, "01-23 12:34:56.789  1234  5678 I MyTag: hello world", 0, "", 1'b0},
        '{-1, "12-31 23:59:59.999 4294967295 4294967296 E Crash:", 0, "", 1'b0},
        '{-1, "99-99 99:99:99.999 99999999999999 7 W Tag:  two spaces", 0, "", 1'b0},
        '{-1, "05-06 07:08:09.010 3 4 D Dbg: d", 0, "", 1'b0},
        '{-1, "07-08 09:10:11.121 5 6 F Fatal: f", 0, "", 1'b0},
        '{-1, "01-01 00:00:00.000 1 1 S Tag:msg\377 no space after colon", 0, "", 1'b0},
        '{-1, "01-01 00:00:00.00012 3 V T: pid straight after millis", 0, "", 1'b0},
        '{-1, "01-01 00:00:00.000 1  2 V a:b:c tag ends at first colon", 0, "", 1'b0},
        // Lines that must be rejected.
        '{-1, "00-00 00:00:00.000 0 0 V T: ", 0, "", 1'b1},
        '{-1, "01-01 00:00:00.000 1 1 D NoColonAtAll", 0, "", 1'b1},
        '{-1, "01-01 00:00:00.000 1 1 F :empty tag", 0, "", 1'b1},
        '{-1, "X", 0, "", 1'b1},
        '{-1, "01/01 00:00:00.000 1 1 S Tag: slash", 0, "", 1'b1},
        '{-1, "01-01 00:00:00.000 1 1 Q Tag: bad level", 0, "", 1'b1},
        '{-1, "01-01 00:00:00.000 1 2  V T: two spaces", 0, "", 1'b1},
        '{-1, "01-01 00:00:00.000 x1 2 I T: letter in pid", 0, "", 1'b1},
        // Register extremes and the boundary of the minimum length.
        '{0, "X", 0, "", 1'b1},
        '{0, "01-01 00:00:00.000 1 1 I T:", 0, "", 1'b0},
        '{27, "01-01 00:00:00.000 1 1 I T:", 0, "", 1'b0},
        '{28, "01-01 00:00:00.000 1 1 I T:", 0, "", 1'b1},
        '{255, "01-23 12:34:56.789  1234  5678 I MyTag: hello world", 0, "", 1'b1},
        // A longer line that still falls short of the largest minimum.
        '{-1, "02-03 04:05:06.789 10 20 W T: ", 150, "", 1'b0}
    };

    logic                            aclk    = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    llfp_pkg::in_item_t              s_data  = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    llfp_pkg::out_item_t             m_data;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [llfp_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [llfp_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [llfp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Records that are still owed by the unit, oldest first.
    llfp_pkg::out_item_t             expected_records [$];
    // The line being composed before it is sent.
    logic [llfp_pkg::CHAR_W-1:0]     line_buf [$];
    int                              mismatch_count = 0;
    int                              quiet_cycles   = 0;
    bit                              idling_on      = 1'b0;
    bit                              long_hold_req  = 1'b0;

    // Our own copy of the parser's line state and of its register.
    parse_phase_t                    cur_phase      = PH_FIXED;
    int                              fixed_slot     = 0;
    logic [llfp_pkg::POS_W-1:0]      cur_pos        = '0;
    bit                              cur_failed     = 1'b0;
    logic [15:0]                     acc_date       = '0;
    logic [35:0]                     acc_time       = '0;
    logic [31:0]                     acc_pid        = '0;
    logic [31:0]                     acc_tid        = '0;
    logic [2:0]                      held_level     = llfp_pkg::LVL_V;
    logic [llfp_pkg::POS_W-1:0]      held_tag_start = '0;
    logic [llfp_pkg::POS_W-1:0]      held_tag_len   = '0;
    logic [llfp_pkg::POS_W-1:0]      held_msg_start = '0;
    logic [llfp_pkg::CHAR_W-1:0]     min_length_reg = llfp_pkg::MIN_LEN_RESET;

    log_line_field_parser_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line parser used for prediction
    // ------------------------------------------------------------------------

    function automatic void start_new_line();
        cur_phase      = PH_FIXED;
        fixed_slot     = 0;
        cur_pos        = '0;
        cur_failed     = 1'b0;
        acc_date       = '0;
        acc_time       = '0;
        acc_pid        = '0;
        acc_tid        = '0;
        held_level     = llfp_pkg::LVL_V;
        held_tag_start = '0;
        held_tag_len   = '0;
        held_msg_start = '0;
    endfunction

    // Positions and lengths stop at the cap instead of wrapping.
    function automatic logic [llfp_pkg::POS_W-1:0] pos_after(
        input logic [llfp_pkg::POS_W-1:0] v);
        return (v == llfp_pkg::POS_CAP) ? v : v + 1'b1;
    endfunction

    // Appends one decimal digit. The sum sticks at 2^32-1 once it overflows.
    function automatic logic [31:0] push_decimal(input logic [31:0] acc,
                                                 input logic [3:0] d);
        logic [35:0] widened;
        widened = {4'd0, acc} * 36'd10 + {32'd0, d};
        return (widened[35:32] != 4'd0) ? 32'hFFFF_FFFF : widened[31:0];
    endfunction

    // Takes one accepted byte. Returns 1 with the record on the last byte.
    function automatic bit parse_byte(input llfp_pkg::in_item_t item,
                                      output llfp_pkg::out_item_t rec);
        logic [llfp_pkg::CHAR_W-1:0] c;
        logic [3:0]                  d;
        bit                          digit;
        logic [llfp_pkg::POS_W-1:0]  here;
        c     = item.char_byte;
        d     = 4'(c - llfp_pkg::CH_ZERO);
        digit = (c >= llfp_pkg::CH_ZERO) && (c <= llfp_pkg::CH_NINE);
        here  = cur_pos;
        rec   = '0;
        // Once a byte has broken the layout, the rest of the line is only counted.
        if (!cur_failed) begin
            case (cur_phase)
                PH_FIXED: begin
                    if (llfp_pkg::FIXED_LAYOUT[fixed_slot] == llfp_pkg::DIGIT_SLOT) begin
                        if (!digit)
                            cur_failed = 1'b1;
                        else if (fixed_slot < llfp_pkg::DATE_SLOTS)
                            acc_date = {acc_date[11:0], d};
                        else
                            acc_time = {acc_time[31:0], d};
                    end else if (c != llfp_pkg::FIXED_LAYOUT[fixed_slot]) begin
                        cur_failed = 1'b1;
                    end
                    if (!cur_failed) begin
                        if (fixed_slot == llfp_pkg::FIXED_LEN - 1)
                            cur_phase = PH_PID_SKIP;
                        else
                            fixed_slot++;
                    end
                end
                PH_PID_SKIP: begin
                    if (c != llfp_pkg::CH_SPACE) begin
                        if (!digit) begin
                            cur_failed = 1'b1;
                        end else begin
                            acc_pid   = push_decimal(acc_pid, d);
                            cur_phase = PH_PID;
                        end
                    end
                end
                PH_PID: begin
                    if (digit)
                        acc_pid = push_decimal(acc_pid, d);
                    else if (c == llfp_pkg::CH_SPACE)
                        cur_phase = PH_TID_SKIP;
                    else
                        cur_failed = 1'b1;
                end
                PH_TID_SKIP: begin
                    if (c != llfp_pkg::CH_SPACE) begin
                        if (!digit) begin
                            cur_failed = 1'b1;
                        end else begin
                            acc_tid   = push_decimal(acc_tid, d);
                            cur_phase = PH_TID;
                        end
                    end
                end
                PH_TID: begin
                    if (digit)
                        acc_tid = push_decimal(acc_tid, d);
                    else if (c == llfp_pkg::CH_SPACE)
                        cur_phase = PH_LEVEL;
                    else
                        cur_failed = 1'b1;
                end
                PH_LEVEL: begin
                    cur_phase = PH_LEVEL_SP;
                    case (c)
                        llfp_pkg::CH_V: held_level = llfp_pkg::LVL_V;
                        llfp_pkg::CH_D: held_level = llfp_pkg::LVL_D;
                        llfp_pkg::CH_I: held_level = llfp_pkg::LVL_I;
                        llfp_pkg::CH_W: held_level = llfp_pkg::LVL_W;
                        llfp_pkg::CH_E: held_level = llfp_pkg::LVL_E;
                        llfp_pkg::CH_F: held_level = llfp_pkg::LVL_F;
                        llfp_pkg::CH_S: held_level = llfp_pkg::LVL_S;
                        default: begin
                            cur_failed = 1'b1;
                            cur_phase  = PH_LEVEL;
                        end
                    endcase
                end
                PH_LEVEL_SP: begin
                    if (c != llfp_pkg::CH_SPACE)
                        cur_failed = 1'b1;
                    else
                        cur_phase = PH_TAG_FIRST;
                end
                PH_TAG_FIRST: begin
                    // An empty tag is a layout error.
                    if (c == llfp_pkg::CH_COLON) begin
                        cur_failed = 1'b1;
                    end else begin
                        held_tag_start = here;
                        held_tag_len   = 12'd1;
                        cur_phase      = PH_TAG;
                    end
                end
                PH_TAG: begin
                    // The tag runs up to the first colon only.
                    if (c == llfp_pkg::CH_COLON) begin
                        held_msg_start = pos_after(here);
                        cur_phase      = PH_AFTER_COLON;
                    end else begin
                        held_tag_len = pos_after(held_tag_len);
                    end
                end
                PH_AFTER_COLON: begin
                    // A single space after the colon is not part of the message.
                    held_msg_start = (c == llfp_pkg::CH_SPACE) ? pos_after(here) : here;
                    cur_phase      = PH_MESSAGE;
                end
                default: ;
            endcase
        end
        cur_pos = pos_after(cur_pos);
        if (!item.last_in_line)
            return 1'b0;

        rec.line_length = cur_pos;
        if (!cur_failed && (cur_phase == PH_AFTER_COLON || cur_phase == PH_MESSAGE)
            && cur_pos >= {4'd0, min_length_reg}) begin
            rec.line_ok        = 1'b1;
            rec.date_bcd       = acc_date;
            rec.time_bcd       = acc_time;
            rec.process_number = acc_pid;
            rec.thread_number  = acc_tid;
            rec.level_code     = held_level;
            rec.tag_offset     = held_tag_start;
            rec.tag_length     = held_tag_len;
            rec.message_offset = held_msg_start;
            case (held_level)
                llfp_pkg::LVL_W:                  rec.severity_code = llfp_pkg::SEV_WARNING;
                llfp_pkg::LVL_E, llfp_pkg::LVL_F: rec.severity_code = llfp_pkg::SEV_ERROR;
                default:                          rec.severity_code = llfp_pkg::SEV_INFO;
            endcase
        end
        start_new_line();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Line composition and driving
    // ------------------------------------------------------------------------

    // Adds one byte at the end of the line being composed.
    function automatic void append_byte(input logic [llfp_pkg::CHAR_W-1:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function automatic void push_digits(input int count);
        repeat (count) append_byte(llfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Most lines follow the layout with random content, so that the parser
    // gets through to the tag and the message. Some are then damaged at one
    // byte or cut short, and a few are plain noise.
    function automatic void compose_random_line();
        int                          pick;
        int                          n;
        int                          i;
        logic [llfp_pkg::CHAR_W-1:0] b;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            n = $urandom_range(1, 40);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
            return;
        end
        for (i = 0; i < llfp_pkg::FIXED_LEN; i++) begin
            if (llfp_pkg::FIXED_LAYOUT[i] == llfp_pkg::DIGIT_SLOT)
                push_digits(1);
            else
                append_byte(llfp_pkg::FIXED_LAYOUT[i]);
        end
        repeat ($urandom_range(0, 3)) append_byte(llfp_pkg::CH_SPACE);
        // Now and then a number long enough to saturate.
        push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(10, 12)
                                                : $urandom_range(1, 5));
        repeat ($urandom_range(1, 3)) append_byte(llfp_pkg::CH_SPACE);
        push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(10, 12)
                                                : $urandom_range(1, 5));
        append_byte(llfp_pkg::CH_SPACE);
        append_byte(LEVEL_LETTERS[$urandom_range(0, 6)]);
        append_byte(llfp_pkg::CH_SPACE);
        // Tag bytes may take any value except the colon.
        repeat ($urandom_range(1, 8)) begin
            b = 8'($urandom_range(0, 254));
            append_byte((b >= llfp_pkg::CH_COLON) ? b + 8'd1 : b);
        end
        append_byte(llfp_pkg::CH_COLON);
        if ($urandom_range(0, 1) == 1)
            append_byte(llfp_pkg::CH_SPACE);
        repeat ($urandom_range(0, 24)) append_byte(8'($urandom_range(0, 255)));
        if (pick < 25) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 35) begin
            n = $urandom_range(1, line_buf.size());
            while (line_buf.size() > n) void'(line_buf.pop_back());
        end
    endfunction

    // Sends line_buf as one line and queues the record it will produce. A
    // rejected line from the table gets its typed-in record instead.
    task automatic send_line(input bit rejected);
        llfp_pkg::in_item_t  item;
        llfp_pkg::out_item_t rec;
        int                  i;
        for (i = 0; i < line_buf.size(); i++) begin
            item.char_byte    = line_buf[i];
            item.last_in_line = (i == line_buf.size() - 1);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data  <= item;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (parse_byte(item, rec)) begin
                if (rejected) begin
                    rec             = '0;
                    rec.line_length = llfp_pkg::POS_W'(line_buf.size());
                end
                expected_records.insert(expected_records.size(), rec);
            end
        end
    endtask

    // The sender stops until every owed record is in and the unit is quiet.
    task automatic wait_for_records();
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A setup cycle and an access cycle. The register is written at the
    // edge that ends the access cycle.
    task automatic write_min_length(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {llfp_pkg::REG_MIN_LINE_LENGTH, 2'b00};
        pwdata  <= llfp_pkg::APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_length_reg = llfp_pkg::CHAR_W'(value);
    endtask

    // ------------------------------------------------------------------------
    // Record checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_record(input llfp_pkg::out_item_t want,
                                           input llfp_pkg::out_item_t got);
        compare_field("line_ok", want.line_ok, got.line_ok);
        compare_field("date_bcd", want.date_bcd, got.date_bcd);
        compare_field("time_bcd", want.time_bcd, got.time_bcd);
        compare_field("process_number", want.process_number, got.process_number);
        compare_field("thread_number", want.thread_number, got.thread_number);
        compare_field("level_code", want.level_code, got.level_code);
        compare_field("severity_code", want.severity_code, got.severity_code);
        compare_field("tag_offset", want.tag_offset, got.tag_offset);
        compare_field("tag_length", want.tag_length, got.tag_length);
        compare_field("message_offset", want.message_offset, got.message_offset);
        compare_field("line_length", want.line_length, got.line_length);
    endfunction

    // Outputs are sampled at the rising edge, before anything driven at that
    // edge has settled, so each record transfer is seen exactly once.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                $display("%0t: record with no line pending, expected none, actual %p",
                         $time, m_data);
                mismatch_count++;
            end else begin
                compare_record(expected_records.pop_front(), m_data);
            end
        end
    end

    // Any transfer on either channel or on the register port counts as
    // progress. A long stretch without one means the unit has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Record receiver. It stalls in short random bursts while idling is on.
    // Once, on request, it holds off for a long stretch, so that the result
    // register stays full and the unit has to stall its byte input.
    initial begin : record_sink
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        line_case_t lc;
        int         row;
        int         i;
        int         stage;
        int         budget;
        int         min_lines;
        int         sent_bytes;
        int         sent_lines;

        start_new_line();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. A register write waits until the unit is idle.
        idling_on = 1'b1;
        for (row = 0; row < NUM_CASES; row++) begin
            lc = line_cases[row];
            if (lc.min_len >= 0) begin
                wait_for_records();
                write_min_length(lc.min_len);
            end
            line_buf.delete();
            for (i = 0; i < lc.head.len(); i++) append_byte(lc.head[i]);
            repeat (lc.fill) append_byte(FILL_CHAR);
            for (i = 0; i < lc.tail.len(); i++) append_byte(lc.tail[i]);
            send_line(lc.rejected);
        end

        // Random lines in four stages: a typical minimum, no minimum, the
        // largest minimum (a brief stage), and a final stage with no idling.
        for (stage = 0; stage < 4; stage++) begin
            wait_for_records();
            case (stage)
                0:       write_min_length($urandom_range(20, 45));
                1:       write_min_length(0);
                2:       write_min_length(255);
                default: write_min_length($urandom_range(0, 80));
            endcase
            idling_on  = (stage != 3);
            budget     = (stage == 2) ? 50 : 200;
            min_lines  = (stage == 2) ? 2 : 4;
            sent_bytes = 0;
            sent_lines = 0;
            if (stage == 0) begin
                // Short lines during the long hold, so that records pile up.
                long_hold_req = 1'b1;
                repeat (12) begin
                    line_buf.delete();
                    repeat ($urandom_range(1, 3))
                        append_byte(8'($urandom_range(0, 255)));
                    send_line(1'b0);
                end
            end
            while (sent_bytes < budget || sent_lines < min_lines) begin
                compose_random_line();
                sent_bytes += line_buf.size();
                sent_lines++;
                send_line(1'b0);
                // The sender also pauses once until every record has come.
                if (stage == 0 && sent_lines == 2)
                    wait_for_records();
            end
        end

        wait_for_records();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
